[sv/voxel_face_mesher_with_occlusion_defines.svh]
// Assertion macros used by the voxel face mesher back end.
`ifndef VOXEL_FACE_MESHER_WITH_OCCLUSION_DEFINES_SVH
`define VOXEL_FACE_MESHER_WITH_OCCLUSION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VFM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/vfm_pkg.sv]
// Types, constants and face tables for the voxel face mesher.
`default_nettype none
package vfm_pkg;

    localparam int CHUNK_EDGE     = 16;
    localparam int NUM_FACES      = 6;
    localparam int VERTS_PER_FACE = 6;
    localparam int CENTER_BIT     = 13;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    localparam logic [2:0] VTX_LAST = 3'(VERTS_PER_FACE - 1);

    typedef logic [5:0][3:0][1:0] t_occ;

    typedef struct packed {
        logic [3:0] px;
        logic [3:0] py;
        logic [3:0] pz;
        logic [5:0] mask;
        t_occ       occ;
    } t_desc;

    // Per face: neighbor bit, edges A, B, C, D, then diagonals of corners 1..4.
    localparam logic [4:0] FACE_BITS [NUM_FACES][9] = '{
        '{5'd4,  5'd3,  5'd1,  5'd5,  5'd7,  5'd0,  5'd2,  5'd8,  5'd6},
        '{5'd22, 5'd21, 5'd19, 5'd23, 5'd25, 5'd18, 5'd20, 5'd26, 5'd24},
        '{5'd10, 5'd9,  5'd1,  5'd11, 5'd19, 5'd0,  5'd2,  5'd20, 5'd18},
        '{5'd16, 5'd15, 5'd7,  5'd17, 5'd25, 5'd6,  5'd8,  5'd26, 5'd24},
        '{5'd12, 5'd9,  5'd3,  5'd15, 5'd21, 5'd0,  5'd6,  5'd24, 5'd18},
        '{5'd14, 5'd11, 5'd5,  5'd17, 5'd23, 5'd2,  5'd8,  5'd26, 5'd20}
    };

    // Vertex entry: {dx, dy, dz, u, v, corner[1:0]}.
    localparam logic [6:0] FACE_VERTS [NUM_FACES][VERTS_PER_FACE] = '{
        '{7'b000_00_00, 7'b100_10_01, 7'b010_01_11,
          7'b100_10_01, 7'b110_11_10, 7'b010_01_11},
        '{7'b011_00_11, 7'b111_10_10, 7'b001_01_00,
          7'b111_10_10, 7'b101_11_01, 7'b001_01_00},
        '{7'b001_00_11, 7'b101_10_10, 7'b000_01_00,
          7'b101_10_10, 7'b100_11_01, 7'b000_01_00},
        '{7'b010_00_00, 7'b110_10_01, 7'b011_01_11,
          7'b110_10_01, 7'b111_11_10, 7'b011_01_11},
        '{7'b000_01_00, 7'b010_00_01, 7'b001_11_11,
          7'b010_00_01, 7'b011_10_10, 7'b001_11_11},
        '{7'b101_01_11, 7'b111_00_10, 7'b100_11_00,
          7'b111_00_10, 7'b110_10_01, 7'b100_11_00}
    };

    // Position reduced into the chunk by repeated subtraction.
    function automatic logic [3:0] chunk_wrap(input logic [3:0] p);
        logic [6:0] r;
        r = {3'b000, p};
        for (int k = 0; k < 8; k++) begin
            if (r >= 7'(CHUNK_EDGE)) begin
                r = r - 7'(CHUNK_EDGE);
            end
        end
        return r[3:0];
    endfunction

endpackage
`default_nettype wire

[sv/vfm_front.sv]
// Front end: accepts voxels, finds exposed faces and corner occlusion levels.
`default_nettype none
module vfm_front
    import vfm_pkg::*;
(
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_local_x,
    input  wire logic [3:0]  i_local_y,
    input  wire logic [3:0]  i_local_z,
    input  wire logic [26:0] i_neighborhood,
    input  wire logic        i_full,
    output logic             o_push,
    output t_desc            o_desc
);

    t_desc w_desc;

    always_comb begin
        logic       ea, eb, ec, ed;
        logic [1:0] lvl [4];
        w_desc    = '0;
        w_desc.px = chunk_wrap(i_local_x);
        w_desc.py = chunk_wrap(i_local_y);
        w_desc.pz = chunk_wrap(i_local_z);
        for (int f = 0; f < NUM_FACES; f++) begin
            w_desc.mask[f] = i_neighborhood[CENTER_BIT] & ~i_neighborhood[FACE_BITS[f][0]];
            ea     = i_neighborhood[FACE_BITS[f][1]];
            eb     = i_neighborhood[FACE_BITS[f][2]];
            ec     = i_neighborhood[FACE_BITS[f][3]];
            ed     = i_neighborhood[FACE_BITS[f][4]];
            lvl[0] = {1'b0, ea} + {1'b0, eb};
            lvl[1] = {1'b0, eb} + {1'b0, ec};
            lvl[2] = {1'b0, ec} + {1'b0, ed};
            lvl[3] = {1'b0, ed} + {1'b0, ea};
            for (int c = 0; c < 4; c++) begin
                if (lvl[c] < 2'd2 && i_neighborhood[FACE_BITS[f][5 + c]]) begin
                    lvl[c] = lvl[c] + 2'd1;
                end
                w_desc.occ[f][c] = lvl[c];
            end
        end
    end

    // Voxels with no exposed face are consumed here and never queued.
    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full & (|w_desc.mask);
    assign o_desc  = w_desc;

endmodule
`default_nettype wire

[sv/vfm_queue.sv]
// Short descriptor queue between the front end and the vertex sequencer.
`default_nettype none
module vfm_queue
    import vfm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_wdata,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_desc      o_rdata,
    output logic       o_empty
);

    t_desc              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_wdata;
                r_wptr        <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));

endmodule
`default_nettype wire

[sv/vfm_back.sv]
// Back end: walks exposed faces and emits six vertices per face.
`default_nettype none
`include "voxel_face_mesher_with_occlusion_defines.svh"
module vfm_back
    import vfm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_desc i_desc,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [4:0] o_vertex_x,
    output logic [4:0] o_vertex_y,
    output logic [4:0] o_vertex_z,
    output logic       o_tex_u,
    output logic       o_tex_v,
    output logic [1:0] o_occlusion,
    output logic [2:0] o_face,
    output logic       o_last
);

    logic       r_busy;
    t_desc      r_desc;
    logic [2:0] r_face;
    logic [2:0] r_vtx;
    logic       r_out_valid;

    logic       w_adv;
    logic       w_is_last;
    logic       w_load;
    logic [3:0] w_next;
    logic [3:0] w_first;
    logic [6:0] w_vert;

    // {found, index} of the lowest set mask bit at or above start.
    function automatic logic [3:0] find_face(input logic [5:0] mask, input logic [2:0] start);
        logic [3:0] res;
        res = '0;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (mask[i] && 3'(i) >= start) begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

    assign w_vert    = FACE_VERTS[r_face][r_vtx];
    assign w_next    = find_face(r_desc.mask, r_face + 3'd1);
    assign w_first   = find_face(i_desc.mask, 3'd0);
    assign w_adv     = r_busy & (~r_out_valid | i_ready);
    assign w_is_last = (r_vtx == VTX_LAST) & ~w_next[3];
    assign w_load    = ~i_empty & (~r_busy | (w_adv & w_is_last));
    assign o_pop     = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                o_vertex_x  <= {1'b0, r_desc.px} + {4'b0000, w_vert[6]};
                o_vertex_y  <= {1'b0, r_desc.py} + {4'b0000, w_vert[5]};
                o_vertex_z  <= {1'b0, r_desc.pz} + {4'b0000, w_vert[4]};
                o_tex_u     <= w_vert[3];
                o_tex_v     <= w_vert[2];
                o_occlusion <= r_desc.occ[r_face][w_vert[1:0]];
                o_face      <= r_face;
                o_last      <= w_is_last;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_load) begin
                r_busy <= 1'b1;
                r_desc <= i_desc;
                r_face <= w_first[2:0];
                r_vtx  <= '0;
            end else if (w_adv) begin
                if (r_vtx == VTX_LAST) begin
                    if (w_next[3]) begin
                        r_face <= w_next[2:0];
                        r_vtx  <= '0;
                    end else begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_vtx <= r_vtx + 3'd1;
                end
            end
        end
    end

    assign o_valid = r_out_valid;

    `VFM_ASSERT_IMPL(a_face_exposed, r_busy, r_desc.mask[r_face], "current face not exposed")
    `VFM_ASSERT_IMPL(a_walk_range, r_busy, (r_face < 3'(NUM_FACES)) && (r_vtx <= VTX_LAST), "face or vertex out of range")
    `VFM_ASSERT_NEXT(a_continue, w_adv && !w_is_last, r_busy, "sequencer dropped a voxel early")
    `VFM_ASSERT_NEXT(a_reload, w_adv && w_is_last, r_busy == $past(!i_empty), "missed queued voxel")

endmodule
`default_nettype wire

[sv/voxel_face_mesher_with_occlusion.sv]
// Top level of the voxel face mesher with corner occlusion.
// Input channel: i_valid/o_ready with one voxel per item (local position and
// 27-bit solid map of its 3x3x3 neighborhood, bit (dz+1)*9+(dy+1)*3+(dx+1)).
// Output channel: o_valid/i_ready with one vertex per item; o_last marks the
// final vertex of a voxel. Six vertices per exposed face, faces in order
// -z, +z, -y, +y, -x, +x, so a voxel yields 0 to 36 items.
// Throughput: one vertex per cycle from the single output register while the
// receiver is ready; voxels that yield nothing are consumed by the front end
// and never queued. When the sequencer is idle, an accepted voxel passes
// through the queue and the sequencer's descriptor register to the output
// register. A two-entry queue decouples acceptance from vertex output, and
// the next voxel is loaded in the cycle its predecessor's last vertex enters
// the output register, so voxels follow each other with no gap.
// Reset (synchronous, active low) empties the queue and the output register.
// When the receiver stalls the current vertex holds; o_ready drops only once
// the queue is full.
`default_nettype none
module voxel_face_mesher_with_occlusion
    import vfm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_local_x,
    input  wire logic [3:0]  i_local_y,
    input  wire logic [3:0]  i_local_z,
    input  wire logic [26:0] i_neighborhood,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_vertex_x,
    output logic [4:0]       o_vertex_y,
    output logic [4:0]       o_vertex_z,
    output logic             o_tex_u,
    output logic             o_tex_v,
    output logic [1:0]       o_occlusion,
    output logic [2:0]       o_face,
    output logic             o_last
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_desc w_wdesc;
    t_desc w_rdesc;

    vfm_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_local_x      (i_local_x),
        .i_local_y      (i_local_y),
        .i_local_z      (i_local_z),
        .i_neighborhood (i_neighborhood),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_desc         (w_wdesc)
    );

    vfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wdesc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_rdesc),
        .o_empty (w_empty)
    );

    vfm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_desc      (w_rdesc),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_vertex_x  (o_vertex_x),
        .o_vertex_y  (o_vertex_y),
        .o_vertex_z  (o_vertex_z),
        .o_tex_u     (o_tex_u),
        .o_tex_v     (o_tex_v),
        .o_occlusion (o_occlusion),
        .o_face      (o_face),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the voxel face mesher: predicts every vertex of each voxel and checks the stream.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT      = 600000;
    localparam int VOXEL_SELF = 13;
    localparam int LONG_HOLD  = 400;

    typedef enum logic [2:0] {
        FACE_NEG_Z, FACE_POS_Z, FACE_NEG_Y, FACE_POS_Y, FACE_NEG_X, FACE_POS_X
    } t_face;

    // neighbor bit, edges A B C D, diagonals of corners 1..4
    localparam int FACE_NB [6][9] = '{
        '{ 4,  3,  1,  5,  7,  0,  2,  8,  6},
        '{22, 21, 19, 23, 25, 18, 20, 26, 24},
        '{10,  9,  1, 11, 19,  0,  2, 20, 18},
        '{16, 15,  7, 17, 25,  6,  8, 26, 24},
        '{12,  9,  3, 15, 21,  0,  6, 24, 18},
        '{14, 11,  5, 17, 23,  2,  8, 26, 20}
    };

    // dx, dy, dz, u, v, corner
    localparam int FACE_VTX [6][6][6] = '{
        '{'{0,0,0,0,0,0},'{1,0,0,1,0,1},'{0,1,0,0,1,3},
          '{1,0,0,1,0,1},'{1,1,0,1,1,2},'{0,1,0,0,1,3}},
        '{'{0,1,1,0,0,3},'{1,1,1,1,0,2},'{0,0,1,0,1,0},
          '{1,1,1,1,0,2},'{1,0,1,1,1,1},'{0,0,1,0,1,0}},
        '{'{0,0,1,0,0,3},'{1,0,1,1,0,2},'{0,0,0,0,1,0},
          '{1,0,1,1,0,2},'{1,0,0,1,1,1},'{0,0,0,0,1,0}},
        '{'{0,1,0,0,0,0},'{1,1,0,1,0,1},'{0,1,1,0,1,3},
          '{1,1,0,1,0,1},'{1,1,1,1,1,2},'{0,1,1,0,1,3}},
        '{'{0,0,0,0,1,0},'{0,1,0,0,0,1},'{0,0,1,1,1,3},
          '{0,1,0,0,0,1},'{0,1,1,1,0,2},'{0,0,1,1,1,3}},
        '{'{1,0,1,0,1,3},'{1,1,1,0,0,2},'{1,0,0,1,1,0},
          '{1,1,1,0,0,2},'{1,1,0,1,0,1},'{1,0,0,1,1,0}}
    };

    typedef struct packed {
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
        logic       u;
        logic       v;
        logic [1:0] occ;
        t_face      face;
        logic       last;
    } t_vertex;

    class vertex_ledger;
        t_vertex due_vertices[$];
        int      mismatches = 0;
        int      matched    = 0;
        int      voxels     = 0;

        function int pending();
            return due_vertices.size();
        endfunction

        function void take_voxel(logic [3:0] px, logic [3:0] py, logic [3:0] pz,
                                 logic [26:0] nb);
            int      lvl [4];
            int      n;
            t_vertex vx;
            voxels++;
            n = 0;
            if (!nb[VOXEL_SELF]) return;
            for (int f = 0; f < 6; f++) begin
                if (nb[FACE_NB[f][0]]) continue;
                lvl[0] = int'(nb[FACE_NB[f][1]]) + int'(nb[FACE_NB[f][2]]);
                lvl[1] = int'(nb[FACE_NB[f][2]]) + int'(nb[FACE_NB[f][3]]);
                lvl[2] = int'(nb[FACE_NB[f][3]]) + int'(nb[FACE_NB[f][4]]);
                lvl[3] = int'(nb[FACE_NB[f][4]]) + int'(nb[FACE_NB[f][1]]);
                for (int c = 0; c < 4; c++) begin
                    if (lvl[c] < 2 && nb[FACE_NB[f][5 + c]]) lvl[c]++;
                end
                for (int k = 0; k < 6; k++) begin
                    vx.x    = 5'(px) + 5'(FACE_VTX[f][k][0]);
                    vx.y    = 5'(py) + 5'(FACE_VTX[f][k][1]);
                    vx.z    = 5'(pz) + 5'(FACE_VTX[f][k][2]);
                    vx.u    = FACE_VTX[f][k][3][0];
                    vx.v    = FACE_VTX[f][k][4][0];
                    vx.occ  = 2'(lvl[FACE_VTX[f][k][5]]);
                    vx.face = t_face'(f);
                    vx.last = 1'b0;
                    due_vertices.push_back(vx);
                    n++;
                end
            end
            if (n > 0) due_vertices[due_vertices.size() - 1].last = 1'b1;
        endfunction

        function void match_vertex(t_vertex got);
            t_vertex want;
            if (due_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d z=%0d face=%0d last=%0b",
                             got.x, got.y, got.z, got.face, got.last);
                return;
            end
            want = due_vertices.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.u !== want.u || got.v !== want.v || got.occ !== want.occ ||
                got.face !== want.face || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("vertex mismatch, exp x=%0d y=%0d z=%0d u=%0b v=%0b occ=%0d face=%0d last=%0b",
                             want.x, want.y, want.z, want.u, want.v, want.occ, want.face,
                             want.last);
                    $display("                 got x=%0d y=%0d z=%0d u=%0b v=%0b occ=%0d face=%0d last=%0b",
                             got.x, got.y, got.z, got.u, got.v, got.occ, got.face, got.last);
                end
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [3:0]  i_local_x      = '0;
    logic [3:0]  i_local_y      = '0;
    logic [3:0]  i_local_z      = '0;
    logic [26:0] i_neighborhood = '0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [4:0]  o_vertex_x;
    logic [4:0]  o_vertex_y;
    logic [4:0]  o_vertex_z;
    logic        o_tex_u;
    logic        o_tex_v;
    logic [1:0]  o_occlusion;
    logic [2:0]  o_face;
    logic        o_last;

    vertex_ledger ledger = new();
    int           cycle_count   = 0;
    bit           tx_idle_on    = 1'b1;
    bit           rx_idle_on    = 1'b1;
    bit           long_hold_req = 1'b0;
    int           stall_left    = 0;

    voxel_face_mesher_with_occlusion dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_local_x      (i_local_x),
        .i_local_y      (i_local_y),
        .i_local_z      (i_local_z),
        .i_neighborhood (i_neighborhood),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_vertex_x     (o_vertex_x),
        .o_vertex_y     (o_vertex_y),
        .o_vertex_z     (o_vertex_z),
        .o_tex_u        (o_tex_u),
        .o_tex_v        (o_tex_v),
        .o_occlusion    (o_occlusion),
        .o_face         (o_face),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready = 1'b0;
        end else if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            i_ready       = 1'b0;
            stall_left    = LONG_HOLD - 1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            i_ready    = 1'b0;
            stall_left = $urandom_range(1, 14) - 1;
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_vertex got;
        if (i_rst_n && o_valid && i_ready) begin
            got.x    = o_vertex_x;
            got.y    = o_vertex_y;
            got.z    = o_vertex_z;
            got.u    = o_tex_u;
            got.v    = o_tex_v;
            got.occ  = o_occlusion;
            got.face = t_face'(o_face);
            got.last = o_last;
            ledger.match_vertex(got);
        end
    end

    task automatic send_voxel(logic [3:0] px, logic [3:0] py, logic [3:0] pz,
                              logic [26:0] nb);
        @(negedge i_clk);
        i_local_x      = px;
        i_local_y      = py;
        i_local_z      = pz;
        i_neighborhood = nb;
        i_valid        = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        ledger.take_voxel(px, py, pz, nb);
    endtask

    task automatic sender_gap();
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [26:0] random_neighborhood();
        logic [26:0] nb;
        nb = 27'($urandom);
        case ($urandom_range(0, 2))
            0: nb = nb & 27'($urandom);
            1: nb = nb | 27'($urandom);
            default: ;
        endcase
        nb[VOXEL_SELF] = ($urandom_range(0, 9) != 0);
        return nb;
    endfunction

    task automatic send_random(int count);
        for (int k = 0; k < count; k++) begin
            send_voxel(4'($urandom), 4'($urandom), 4'($urandom), random_neighborhood());
            sender_gap();
        end
    endtask

    localparam logic [26:0] SELF_ONLY = 27'(1) << VOXEL_SELF;
    localparam logic [26:0] ALL_SOLID = '1;
    localparam logic [26:0] CORNERS   = SELF_ONLY | 27'h5_14_0145;
    localparam logic [26:0] EDGES     = SELF_ONLY | 27'h2_A8_A8AA;

    initial begin
        logic [26:0] nb;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty and enclosed voxels, exposure, occlusion extremes
        send_voxel(4'd0, 4'd0, 4'd0, '0);
        send_voxel(4'd15, 4'd15, 4'd15, ALL_SOLID & ~SELF_ONLY);
        send_voxel(4'd7, 4'd3, 4'd9, ALL_SOLID);
        send_voxel(4'd0, 4'd0, 4'd0, SELF_ONLY);
        send_voxel(4'd15, 4'd15, 4'd15, SELF_ONLY);
        send_voxel(4'd15, 4'd0, 4'd15, CORNERS);
        send_voxel(4'd0, 4'd15, 4'd0, EDGES);
        nb = ALL_SOLID;
        for (int f = 0; f < 6; f++) begin
            nb[FACE_NB[f][0]] = 1'b0;
            send_voxel(4'($urandom), 4'($urandom), 4'($urandom),
                       ALL_SOLID & ~(27'(1) << FACE_NB[f][0]));
        end
        send_voxel(4'd15, 4'd15, 4'd15, nb);
        for (int f = 0; f < 6; f++) begin
            // one edge plus the diagonal it meets
            send_voxel(4'd8, 4'd8, 4'd8, SELF_ONLY | (27'(1) << FACE_NB[f][1]) |
                       (27'(1) << FACE_NB[f][5]));
        end
        sender_gap();

        send_random(50);

        // long receiver hold while the sender keeps offering
        wait_drained();
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        for (int k = 0; k < 10; k++)
            send_voxel(4'($urandom), 4'($urandom), 4'($urandom), SELF_ONLY);
        tx_idle_on = 1'b1;

        // sender pauses until every vertex has come out
        wait_drained();
        send_random(50);

        wait_drained();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random(20);

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("voxels accepted: %0d, vertices matched: %0d, mismatches: %0d",
                 ledger.voxels, ledger.matched, ledger.mismatches);
        $display("covered empty, enclosed and exposed voxels, occlusion levels 0..2, stalls");
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/vfm_pkg.sv
sv/vfm_front.sv
sv/vfm_queue.sv
sv/vfm_back.sv
sv/voxel_face_mesher_with_occlusion.sv
sim/tb.sv
